// ----- rtl/core/rgb_to_sixteen_color_index_assert.svh -----
// Assertion macros used by the RTL of the color index block.
`ifndef RGB_TO_SIXTEEN_COLOR_INDEX_ASSERT_SVH
`define RGB_TO_SIXTEEN_COLOR_INDEX_ASSERT_SVH

// Checked on the rising clock edge and ignored while reset is asserted.
`define RGBSCI_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) prop) else $error(msg);

// Checked on every rising clock edge, including during reset.
`define RGBSCI_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- rtl/core/rgbsci_pkg.sv -----
`default_nettype none

package rgbsci_pkg;

    localparam int unsigned ChanWidth  = 8;
    localparam int unsigned IndexWidth = 5;

    typedef logic [ChanWidth-1:0]  chan_t;
    typedef logic [IndexWidth-1:0] index_t;

    typedef struct packed {
        chan_t blue_level;
        chan_t green_level;
        chan_t red_level;
    } pixel_t;

    localparam index_t PAL_RED        = 5'd1;
    localparam index_t PAL_YELLOW     = 5'd2;
    localparam index_t PAL_GREEN      = 5'd3;
    localparam index_t PAL_CYAN       = 5'd4;
    localparam index_t PAL_BLUE       = 5'd5;
    localparam index_t PAL_MAGENTA    = 5'd6;
    localparam index_t PAL_WHITE      = 5'd7;
    localparam index_t PAL_BLACK      = 5'd8;
    localparam index_t PAL_LIGHT_GREY = 5'd15;
    localparam index_t PAL_DARK_GREY  = 5'd16;

    // Value thresholds for 0.15, 0.5 and 0.75 of full scale.
    localparam chan_t BLACK_TOP = 8'd38;
    localparam chan_t DARK_TOP  = 8'd127;
    localparam chan_t LIGHT_TOP = 8'd191;

endpackage

`default_nettype wire

// ----- rtl/core/rgbsci_classify.sv -----
`default_nettype none

module rgbsci_classify (
    input  rgbsci_pkg::pixel_t pixel,
    output rgbsci_pkg::index_t palette_index
);
    import rgbsci_pkg::*;

    chan_t              hi;
    chan_t              lo;
    chan_t              delta;
    logic [10:0]        five_delta;
    logic               saturated;
    chan_t              diff_a;
    chan_t              diff_b;
    index_t             code_below;
    index_t             code_mid;
    index_t             code_above;
    logic signed [9:0]  diff;
    logic signed [9:0]  twice;
    logic signed [9:0]  delta_s;
    index_t             hue_code;
    index_t             grey_code;

    always_comb begin
        hi = pixel.red_level;
        lo = pixel.red_level;
        if (pixel.green_level > hi) hi = pixel.green_level;
        if (pixel.blue_level > hi)  hi = pixel.blue_level;
        if (pixel.green_level < lo) lo = pixel.green_level;
        if (pixel.blue_level < lo)  lo = pixel.blue_level;
    end

    assign delta      = hi - lo;
    assign five_delta = {1'b0, delta, 2'b00} + {3'b000, delta};
    assign saturated  = (delta != '0) && (five_delta >= {3'b000, hi});

    // The hue sector is found from the two channels other than the maximum.
    always_comb begin
        if (pixel.red_level == hi) begin
            diff_a     = pixel.green_level;
            diff_b     = pixel.blue_level;
            code_below = PAL_MAGENTA;
            code_mid   = PAL_RED;
            code_above = PAL_YELLOW;
        end else if (pixel.green_level == hi) begin
            diff_a     = pixel.blue_level;
            diff_b     = pixel.red_level;
            code_below = PAL_YELLOW;
            code_mid   = PAL_GREEN;
            code_above = PAL_CYAN;
        end else begin
            diff_a     = pixel.red_level;
            diff_b     = pixel.green_level;
            code_below = PAL_CYAN;
            code_mid   = PAL_BLUE;
            code_above = PAL_MAGENTA;
        end
    end

    assign diff    = signed'({2'b00, diff_a}) - signed'({2'b00, diff_b});
    assign twice   = diff <<< 1;
    assign delta_s = signed'({2'b00, delta});

    always_comb begin
        if (twice < -delta_s) begin
            hue_code = code_below;
        end else if (twice < delta_s) begin
            hue_code = code_mid;
        end else begin
            hue_code = code_above;
        end
    end

    always_comb begin
        if (delta == '0) begin
            grey_code = PAL_WHITE;
        end else if (hi <= BLACK_TOP) begin
            grey_code = PAL_BLACK;
        end else if (hi <= DARK_TOP) begin
            grey_code = PAL_DARK_GREY;
        end else if (hi <= LIGHT_TOP) begin
            grey_code = PAL_LIGHT_GREY;
        end else begin
            grey_code = PAL_WHITE;
        end
    end

    assign palette_index = saturated ? hue_code : grey_code;

endmodule

`default_nettype wire

// ----- rtl/core/rgb_to_sixteen_color_index.sv -----
// Channel  Dir  Width  Contents
// s_axis   in   24     red_level, green_level, blue_level (from bit 0 up)
// m_axis   out  8      palette_index, zero filled
//
// A beat is registered on input, classified by a single combinational pass
// and registered again on output. One beat is accepted in every cycle
// while the output side keeps up. The input register refills whenever
// its content moves to the output register, so s_tready follows m_tready
// through one gate.
// aresetn is synchronous and active low and clears both valid flags.
`default_nettype none

`include "rgb_to_sixteen_color_index_assert.svh"

module rgb_to_sixteen_color_index (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [23:0] s_tdata,   // red_level, green_level, blue_level
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [7:0]       m_tdata    // palette_index, zero filled
);
    import rgbsci_pkg::*;

    logic   in_valid_reg;
    logic   in_valid_next;
    pixel_t pixel_reg;
    logic   out_valid_reg;
    logic   out_valid_next;
    index_t index_reg;
    index_t index_comb;
    logic   advance;
    logic   s_accept;

    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;
    assign s_accept = s_tvalid && s_tready;

    assign in_valid_next  = s_accept || (in_valid_reg && !advance);
    assign out_valid_next = advance || (out_valid_reg && !m_tready);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            pixel_reg <= pixel_t'(s_tdata);
        end
        if (advance) begin
            index_reg <= index_comb;
        end
    end

    rgbsci_classify u_classify (
        .pixel         (pixel_reg),
        .palette_index (index_comb)
    );

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {3'b000, index_reg};

    `RGBSCI_ASSERT_ALWAYS(a_reset_clears, aclk, !aresetn |=> !m_tvalid && !in_valid_reg, "valid after reset")
    `RGBSCI_ASSERT(a_hold_in, aclk, aresetn, in_valid_reg && out_valid_reg && !m_tready |=> in_valid_reg && $stable(pixel_reg), "input stage lost a stalled beat")
    `RGBSCI_ASSERT(a_no_overrun, aclk, aresetn, s_accept && in_valid_reg |-> advance, "input stage overwritten")
    `RGBSCI_ASSERT(a_code_ok, aclk, aresetn, m_tvalid |-> (index_reg >= PAL_RED && index_reg <= PAL_BLACK) || index_reg == PAL_LIGHT_GREY || index_reg == PAL_DARK_GREY, "bad palette code")

endmodule

`default_nettype wire
